/* hw/rtl/aksm_pkg.sv */
// ============================================================================
// aksm_pkg: shared types and constants for the keyword substring matcher
// Register map codes, transaction payload structs and default sizes.
// ============================================================================
package aksm_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_KEYWORDS_DEF = 4;
    localparam int KEY_LEN_DEF      = 8;

    // Fixed field widths of the register map and the result
    localparam int KEY_SLOTS  = 4;
    localparam int LEN_W      = 4;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int BYTE_W     = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEYWORD_COUNT   = 3'd0,
        REG_KEYWORD_CHARS_0 = 3'd1,
        REG_KEYWORD_CHARS_1 = 3'd2,
        REG_KEYWORD_CHARS_2 = 3'd3,
        REG_KEYWORD_CHARS_3 = 3'd4,
        REG_KEYWORD_LENGTHS = 3'd5
    } t_cfg_reg;

    // One input transaction
    typedef struct packed {
        logic [BYTE_W-1:0] url_byte;
        logic              url_last;
        logic              url_empty;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic                 url_matches;
        logic [KEY_SLOTS-1:0] keyword_hits;
    } t_result;

endpackage

/* hw/rtl/aksm_in_if.sv */
// ============================================================================
// aksm_in_if: URL byte channel
// Valid/ready channel that carries one URL byte with its framing flags.
// ============================================================================
interface aksm_in_if;
    logic                          valid;
    logic                          ready;
    logic [aksm_pkg::BYTE_W-1:0]   url_byte;
    logic                          url_last;
    logic                          url_empty;

    modport source (output valid, output url_byte, output url_last, output url_empty,
                    input ready);
    modport sink   (input valid, input url_byte, input url_last, input url_empty,
                    output ready);
endinterface

/* hw/rtl/aksm_out_if.sv */
// ============================================================================
// aksm_out_if: match result channel
// Valid/ready channel that carries the verdict and keyword hits of one URL.
// ============================================================================
interface aksm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           url_matches;
    logic [aksm_pkg::KEY_SLOTS-1:0] keyword_hits;

    modport source (output valid, output url_matches, output keyword_hits, input ready);
    modport sink   (input valid, input url_matches, input keyword_hits, output ready);
endinterface

/* hw/rtl/all_keywords_substring_match_core.sv */
// Keyword substring matcher. URL bytes enter one per transaction on i_url;
// each keyword in use (up to four, up to eight bytes each) is searched as a
// case-sensitive substring of the current URL, and a transaction marked last
// or empty yields one result on o_res: the URL matches when every keyword in
// use was found. The block takes one byte every clock cycle while i_url.ready
// is high; a result passes through the input register and the result register
// around the combinational window compare. i_url.ready drops only while a
// URL-ending byte waits behind a result that has not been taken. Program the
// registers only while the block is idle.
// ============================================================================
// all_keywords_substring_match_core: top level of the keyword matcher
// Input register, window matcher, result register and configuration port.
// ============================================================================
module all_keywords_substring_match_core #(
    parameter int MAX_KEYWORDS = aksm_pkg::MAX_KEYWORDS_DEF,
    parameter int KEY_LEN      = aksm_pkg::KEY_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    aksm_in_if.sink                          i_url,
    aksm_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [aksm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aksm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                r_in_valid;
    aksm_pkg::t_item     r_item;
    logic                r_out_valid;
    aksm_pkg::t_result   r_result;

    logic                advance;
    logic                produces;
    logic                in_fire;
    aksm_pkg::t_result   step_result;

    logic [MAX_KEYWORDS-1:0][KEY_LEN*aksm_pkg::BYTE_W-1:0] key_chars;
    logic [MAX_KEYWORDS-1:0][aksm_pkg::LEN_W-1:0]          key_lens;
    logic [MAX_KEYWORDS-1:0]                               key_mask;

    aksm_cfg_regs #(
        .MAX_KEYWORDS (MAX_KEYWORDS),
        .KEY_LEN      (KEY_LEN)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key_chars (key_chars),
        .o_key_lens  (key_lens),
        .o_key_mask  (key_mask)
    );

    aksm_matcher #(
        .MAX_KEYWORDS (MAX_KEYWORDS),
        .KEY_LEN      (KEY_LEN)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (r_item),
        .i_key_chars (key_chars),
        .i_key_lens  (key_lens),
        .i_key_mask  (key_mask),
        .o_result    (step_result)
    );

    // Advance the held transaction unless its result has nowhere to go
    assign produces    = r_item.url_last | r_item.url_empty;
    assign advance     = r_in_valid & (~produces | ~r_out_valid | o_res.ready);
    assign i_url.ready = ~r_in_valid | advance;
    assign in_fire     = i_url.valid & i_url.ready;

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.url_byte  <= i_url.url_byte;
            r_item.url_last  <= i_url.url_last;
            r_item.url_empty <= i_url.url_empty;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produces) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produces) begin
            r_result <= step_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.url_matches  = r_result.url_matches;
    assign o_res.keyword_hits = r_result.keyword_hits;

endmodule

/* hw/rtl/aksm_cfg_regs.sv */
// ============================================================================
// aksm_cfg_regs: keyword configuration registers
// Holds keyword bytes, lengths and count; presents clamped lengths and the
// mask of keywords in use.
// ============================================================================
module aksm_cfg_regs #(
    parameter int MAX_KEYWORDS = aksm_pkg::MAX_KEYWORDS_DEF,
    parameter int KEY_LEN      = aksm_pkg::KEY_LEN_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [aksm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [aksm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic [MAX_KEYWORDS-1:0][KEY_LEN*aksm_pkg::BYTE_W-1:0] o_key_chars,
    output logic [MAX_KEYWORDS-1:0][aksm_pkg::LEN_W-1:0]          o_key_lens,
    output logic [MAX_KEYWORDS-1:0]                               o_key_mask
);

    localparam int CW = aksm_pkg::COUNT_W;
    localparam int LW = aksm_pkg::LEN_W;

    logic [CW-1:0]                                      r_key_count;
    logic [MAX_KEYWORDS-1:0][LW-1:0]                    r_key_lens;
    logic [MAX_KEYWORDS-1:0][KEY_LEN*aksm_pkg::BYTE_W-1:0] r_key_chars;
    logic [CW-1:0]                                      keys_used;

    // Take register writes; writes beyond the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_key_lens  <= '0;
            r_key_chars <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == aksm_pkg::REG_KEYWORD_COUNT) begin
                r_key_count <= i_cfg_data[CW-1:0];
            end
            if (i_cfg_index == aksm_pkg::REG_KEYWORD_LENGTHS) begin
                for (int k = 0; k < MAX_KEYWORDS; k++) begin
                    r_key_lens[k] <= i_cfg_data[LW*k +: LW];
                end
            end
            for (int k = 0; k < MAX_KEYWORDS; k++) begin
                if (i_cfg_index ==
                    aksm_pkg::CFG_IDX_W'(int'(aksm_pkg::REG_KEYWORD_CHARS_0) + k)) begin
                    r_key_chars[k] <= i_cfg_data[KEY_LEN*aksm_pkg::BYTE_W-1:0];
                end
            end
        end
    end

    // Clamp count and lengths, build the in-use mask
    always_comb begin
        keys_used = (r_key_count > CW'(MAX_KEYWORDS)) ? CW'(MAX_KEYWORDS) : r_key_count;
        for (int k = 0; k < MAX_KEYWORDS; k++) begin
            o_key_mask[k] = (CW'(k) < keys_used);
            o_key_lens[k] = (r_key_lens[k] > LW'(KEY_LEN)) ? LW'(KEY_LEN) : r_key_lens[k];
        end
    end

    assign o_key_chars = r_key_chars;

endmodule

/* hw/rtl/aksm_matcher.sv */
// ============================================================================
// aksm_matcher: sliding window compare and per-URL hit tracking
// Compares the newest bytes against every keyword, keeps hit flags and
// forms the verdict at the end of a URL.
// ============================================================================
module aksm_matcher #(
    parameter int MAX_KEYWORDS = aksm_pkg::MAX_KEYWORDS_DEF,
    parameter int KEY_LEN      = aksm_pkg::KEY_LEN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  aksm_pkg::t_item         i_item,
    input  logic [MAX_KEYWORDS-1:0][KEY_LEN*aksm_pkg::BYTE_W-1:0] i_key_chars,
    input  logic [MAX_KEYWORDS-1:0][aksm_pkg::LEN_W-1:0]          i_key_lens,
    input  logic [MAX_KEYWORDS-1:0]                               i_key_mask,
    output aksm_pkg::t_result       o_result
);

    localparam int BW     = aksm_pkg::BYTE_W;
    localparam int LW     = aksm_pkg::LEN_W;
    localparam int WIN_D  = (KEY_LEN > 1) ? KEY_LEN - 1 : 1;
    localparam int FILL_W = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    logic [BW-1:0]           r_window [WIN_D];
    logic [FILL_W-1:0]       r_fill;
    logic [MAX_KEYWORDS-1:0] r_flags;

    logic [KEY_LEN-1:0][BW-1:0] cur;
    logic [LW-1:0]              avail;
    logic [MAX_KEYWORDS-1:0]    hit_now;
    logic [MAX_KEYWORDS-1:0]    hit_empty;
    logic [MAX_KEYWORDS-1:0]    flags_all;
    logic [MAX_KEYWORDS-1:0]    hits;
    logic                       url_done;

    // Compare every keyword against the window ending at the current byte
    always_comb begin
        logic ok;
        ok = 1'b1;
        cur[0] = i_item.url_byte;
        for (int j = 1; j < KEY_LEN; j++) begin
            cur[j] = r_window[j-1];
        end
        avail = LW'(r_fill) + LW'(1);
        for (int k = 0; k < MAX_KEYWORDS; k++) begin
            hit_now[k] = 1'b0;
            for (int l = 1; l <= KEY_LEN; l++) begin
                ok = 1'b1;
                for (int i = 0; i < l; i++) begin
                    if (i_key_chars[k][BW*i +: BW] != cur[l-1-i]) begin
                        ok = 1'b0;
                    end
                end
                if (ok && (i_key_lens[k] == LW'(l)) && (LW'(l) <= avail)) begin
                    hit_now[k] = 1'b1;
                end
            end
            hit_now[k]   = hit_now[k] & i_key_mask[k];
            hit_empty[k] = i_key_mask[k] & (i_key_lens[k] == '0);
        end
        flags_all = r_flags | hit_now;
        hits      = i_item.url_empty ? hit_empty : (flags_all & i_key_mask);
        url_done  = i_item.url_last | i_item.url_empty;
    end

    // Form the verdict
    always_comb begin
        o_result              = '0;
        o_result.url_matches  = (hits == i_key_mask);
        for (int k = 0; k < MAX_KEYWORDS; k++) begin
            o_result.keyword_hits[k] = hits[k];
        end
    end

    // Advance fill count and hit flags; clear them at the end of a URL
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_flags <= '0;
        end else if (i_advance) begin
            if (url_done) begin
                r_fill  <= '0;
                r_flags <= '0;
            end else begin
                r_flags <= flags_all;
                if (r_fill < FILL_W'(KEY_LEN - 1)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // Shift the byte window; bytes past the fill count are never compared
    always_ff @(posedge i_clk) begin
        if (i_advance && !i_item.url_empty) begin
            r_window[0] <= i_item.url_byte;
            for (int j = 1; j < WIN_D; j++) begin
                r_window[j] <= r_window[j-1];
            end
        end
    end

endmodule

/* hw/rtl/aksm_checker.sv */
// ============================================================================
// aksm_checker: port-level checks for the keyword matcher
// Watches the channels of the top level and flags broken behavior.
// ============================================================================
module aksm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_last,
    input logic                           i_in_empty,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_matches,
    input logic [aksm_pkg::KEY_SLOTS-1:0] i_out_hits
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_matches) && $stable(i_out_hits))
        else $error("result changed while stalled");

    // Drop input ready only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a stalled result");

    // Deliver the result of a URL-ending transaction once it is held and the output is free
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_last || i_in_empty)
            ##1 (!i_out_valid || i_out_ready) |=> i_out_valid)
        else $error("result missing after URL end");

    // Report a match whenever every keyword slot hit
    a_all_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_hits == '1) |-> i_out_matches)
        else $error("all keywords hit but no match reported");

endmodule

bind all_keywords_substring_match_core aksm_checker u_aksm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_url.valid),
    .i_in_ready    (i_url.ready),
    .i_in_last     (i_url.url_last),
    .i_in_empty    (i_url.url_empty),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_matches (o_res.url_matches),
    .i_out_hits    (o_res.keyword_hits)
);

/* bench/all_keywords_substring_match_core_tb.sv */
// ============================================================================
// all_keywords_substring_match_core_tb: self-checking bench for the matcher
// Streams URL bytes through the matcher under several keyword settings and
// compares every verdict with a cycle-free software predictor. A table of
// directed transactions covers the edge cases, then random URLs built from
// the programmed keywords follow, with random gaps on both channels.
// ============================================================================
module all_keywords_substring_match_core_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_KW       = aksm_pkg::MAX_KEYWORDS_DEF;
    localparam int KLEN         = aksm_pkg::KEY_LEN_DEF;
    localparam int TAIL_D       = KLEN - 1;
    localparam int TOTAL_ITEMS  = 1350;
    localparam int CALM_ITEMS   = 200;
    localparam int QUIET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;

    // Indexes past the end of the register map
    localparam logic [aksm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [aksm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic [aksm_pkg::BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [aksm_pkg::BYTE_W-1:0] CH_B = 8'h62;
    localparam logic [aksm_pkg::BYTE_W-1:0] CH_C = 8'h63;

    typedef enum logic {ROW_CFG, ROW_URL} t_row_kind;

    typedef struct {
        t_row_kind                        kind;
        logic [aksm_pkg::CFG_IDX_W-1:0]   idx;
        logic [aksm_pkg::CFG_DATA_W-1:0]  data;
        aksm_pkg::t_item                  item;
        bit                               typed;
        aksm_pkg::t_result                want;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [aksm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [aksm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    aksm_in_if  url_if ();
    aksm_out_if res_if ();

    all_keywords_substring_match_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_url       (url_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the registers and the per-URL state
    logic [aksm_pkg::COUNT_W-1:0]                  kw_count;
    logic [aksm_pkg::CFG_DATA_W-1:0]               kw_chars [0:aksm_pkg::KEY_SLOTS-1];
    logic [aksm_pkg::KEY_SLOTS*aksm_pkg::LEN_W-1:0] kw_lens;
    logic [aksm_pkg::BYTE_W-1:0]                   tail [0:TAIL_D-1];
    int unsigned                                   tail_fill;
    logic [aksm_pkg::KEY_SLOTS-1:0]                url_hits;

    aksm_pkg::t_result           verdict_q [$];
    t_dir_row                    dir_rows [$];
    int unsigned                 mismatches = 0;
    int unsigned                 items_sent = 0;
    bit                          idle_on = 1'b1;
    logic [aksm_pkg::BYTE_W-1:0] alpha_lo = '0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Effective length of keyword k after the clamp
    function automatic int unsigned kw_len(input int unsigned k);
        int unsigned l;
        l = kw_lens[aksm_pkg::LEN_W*k +: aksm_pkg::LEN_W];
        return (l > KLEN) ? KLEN : l;
    endfunction

    function automatic void clear_url();
        foreach (tail[j]) tail[j] = '0;
        tail_fill = 0;
        url_hits  = '0;
    endfunction

    // Advance the URL state by one transaction; return 1 with the verdict
    // when the transaction closes a URL
    function automatic bit predict_verdict(input aksm_pkg::t_item it,
                                           output aksm_pkg::t_result res);
        logic [aksm_pkg::BYTE_W-1:0]    cur [0:KLEN-1];
        logic [aksm_pkg::KEY_SLOTS-1:0] mask;
        logic [aksm_pkg::KEY_SLOTS-1:0] hits;
        int unsigned                    used;
        int unsigned                    avail;
        int unsigned                    len;
        bit                             ok;
        used = (kw_count > MAX_KW) ? MAX_KW : kw_count;
        mask = aksm_pkg::KEY_SLOTS'((5'd1 << used) - 5'd1);
        res  = '0;
        // Empty URL: only empty keywords hit, partial URL is dropped
        if (it.url_empty) begin
            hits = '0;
            for (int k = 0; k < used; k++)
                if (kw_len(k) == 0) hits[k] = 1'b1;
            res.url_matches  = (hits == mask);
            res.keyword_hits = hits;
            clear_url();
            return 1'b1;
        end
        cur[0] = it.url_byte;
        for (int j = 1; j < KLEN; j++) cur[j] = tail[j-1];
        avail = tail_fill + 1;
        // Compare each keyword against the newest bytes, oldest byte first
        for (int k = 0; k < used; k++) begin
            len = kw_len(k);
            if (len == 0 || len > avail) continue;
            ok = 1'b1;
            for (int i = 0; i < len; i++)
                if (kw_chars[k][8*i +: 8] != cur[len-1-i]) ok = 1'b0;
            if (ok) url_hits[k] = 1'b1;
        end
        for (int j = 0; j < TAIL_D; j++) tail[j] = cur[j];
        if (tail_fill < TAIL_D) tail_fill++;
        if (it.url_last) begin
            hits = url_hits & mask;
            res.url_matches  = (hits == mask);
            res.keyword_hits = hits;
            clear_url();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void cfg_row(input logic [aksm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [aksm_pkg::CFG_DATA_W-1:0] data);
        t_dir_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.item  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void url_row(input logic [aksm_pkg::BYTE_W-1:0] b,
                                    input logic last, input logic empty);
        t_dir_row r;
        r.kind           = ROW_URL;
        r.idx            = '0;
        r.data           = '0;
        r.item.url_byte  = b;
        r.item.url_last  = last;
        r.item.url_empty = empty;
        r.typed          = 1'b0;
        r.want           = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void known_row(input logic [aksm_pkg::BYTE_W-1:0] b,
                                      input logic last, input logic empty,
                                      input logic m,
                                      input logic [aksm_pkg::KEY_SLOTS-1:0] h);
        url_row(b, last, empty);
        dir_rows[$].typed             = 1'b1;
        dir_rows[$].want.url_matches  = m;
        dir_rows[$].want.keyword_hits = h;
    endfunction

    // Write one register and mirror it into the predictor
    task automatic write_reg(input logic [aksm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [aksm_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            aksm_pkg::REG_KEYWORD_COUNT:   kw_count    = data[aksm_pkg::COUNT_W-1:0];
            aksm_pkg::REG_KEYWORD_CHARS_0: kw_chars[0] = data;
            aksm_pkg::REG_KEYWORD_CHARS_1: kw_chars[1] = data;
            aksm_pkg::REG_KEYWORD_CHARS_2: kw_chars[2] = data;
            aksm_pkg::REG_KEYWORD_CHARS_3: kw_chars[3] = data;
            aksm_pkg::REG_KEYWORD_LENGTHS:
                kw_lens = data[aksm_pkg::KEY_SLOTS*aksm_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Hold the input, drain all results and let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        url_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Drive one URL transaction, wait for the handshake, record the verdict
    task automatic send_item(input aksm_pkg::t_item it, input bit typed,
                             input aksm_pkg::t_result want);
        aksm_pkg::t_result pred;
        int unsigned       gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            url_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        url_if.valid     <= 1'b1;
        url_if.url_byte  <= it.url_byte;
        url_if.url_last  <= it.url_last;
        url_if.url_empty <= it.url_empty;
        @(posedge i_clk);
        while (!url_if.ready) @(posedge i_clk);
        if (predict_verdict(it, pred))
            verdict_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // Program a keyword set: phase 0 all ones, phase 1 all zeros, then random
    task automatic program_keywords(input int phase);
        logic [aksm_pkg::CFG_DATA_W-1:0]                chars [0:aksm_pkg::KEY_SLOTS-1];
        logic [aksm_pkg::CFG_DATA_W-1:0]                filler;
        logic [aksm_pkg::KEY_SLOTS*aksm_pkg::LEN_W-1:0] lens;
        logic [aksm_pkg::COUNT_W-1:0]                   cnt;
        int unsigned                                    pick;
        if (phase == 0) begin
            alpha_lo = 8'd253;
            filler   = '1;
            cnt      = '1;
            lens     = '1;
            foreach (chars[k]) chars[k] = '1;
        end else if (phase == 1) begin
            alpha_lo = '0;
            filler   = '0;
            cnt      = '0;
            lens     = '0;
            foreach (chars[k]) chars[k] = '0;
        end else begin
            alpha_lo = 8'($urandom_range(0, 253));
            filler   = {$urandom, $urandom};
            cnt = ($urandom_range(0, 9) < 2) ? aksm_pkg::COUNT_W'($urandom_range(0, 7))
                                             : aksm_pkg::COUNT_W'($urandom_range(1, 4));
            for (int k = 0; k < aksm_pkg::KEY_SLOTS; k++) begin
                for (int i = 0; i < KLEN; i++)
                    chars[k][8*i +: 8] = ($urandom_range(0, 6) == 0) ?
                        8'($urandom_range(0, 255)) : 8'(alpha_lo + $urandom_range(0, 2));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    lens[aksm_pkg::LEN_W*k +: aksm_pkg::LEN_W] = '0;
                else if (pick == 1)
                    lens[aksm_pkg::LEN_W*k +: aksm_pkg::LEN_W] =
                        aksm_pkg::LEN_W'($urandom_range(9, 15));
                else if (pick == 2)
                    lens[aksm_pkg::LEN_W*k +: aksm_pkg::LEN_W] =
                        aksm_pkg::LEN_W'($urandom_range(6, 8));
                else
                    lens[aksm_pkg::LEN_W*k +: aksm_pkg::LEN_W] =
                        aksm_pkg::LEN_W'($urandom_range(1, 4));
            end
        end
        // Unused upper bits carry filler so they get exercised too
        write_reg(aksm_pkg::REG_KEYWORD_COUNT,
                  {filler[aksm_pkg::CFG_DATA_W-1:aksm_pkg::COUNT_W], cnt});
        write_reg(aksm_pkg::REG_KEYWORD_CHARS_0, chars[0]);
        write_reg(aksm_pkg::REG_KEYWORD_CHARS_1, chars[1]);
        write_reg(aksm_pkg::REG_KEYWORD_CHARS_2, chars[2]);
        write_reg(aksm_pkg::REG_KEYWORD_CHARS_3, chars[3]);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO, filler);
        write_reg(aksm_pkg::REG_KEYWORD_LENGTHS,
                  {filler[aksm_pkg::CFG_DATA_W-1:aksm_pkg::KEY_SLOTS*aksm_pkg::LEN_W], lens});
    endtask

    // Build one URL from keyword copies, near misses and alphabet bytes;
    // now and then send an empty URL alone or drop one into the middle of it
    task automatic send_url();
        logic [aksm_pkg::BYTE_W-1:0] body [$];
        aksm_pkg::t_item             it;
        aksm_pkg::t_result           none;
        int unsigned                 want_len;
        int unsigned                 pick;
        int unsigned                 k;
        int unsigned                 len;
        int                          cut;
        none = '0;
        if ($urandom_range(0, 11) == 0) begin
            it.url_byte  = 8'($urandom_range(0, 255));
            it.url_last  = 1'($urandom_range(0, 1));
            it.url_empty = 1'b1;
            send_item(it, 1'b0, none);
            return;
        end
        want_len = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 30)
                                                : $urandom_range(1, 12);
        while (body.size() < want_len) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, aksm_pkg::KEY_SLOTS - 1);
            if (pick < 40) begin
                len = kw_len(k);
                if (len > 1 && $urandom_range(0, 3) == 0) len--;
                for (int i = 0; i < len; i++) body.push_back(kw_chars[k][8*i +: 8]);
            end else if (pick < 48) begin
                body.push_back(8'($urandom_range(0, 255)));
            end else begin
                body.push_back(8'(alpha_lo + $urandom_range(0, 2)));
            end
        end
        cut = (body.size() > 1 && $urandom_range(0, 19) == 0) ?
              $urandom_range(1, body.size() - 1) : -1;
        foreach (body[i]) begin
            if (i == cut) begin
                it.url_byte  = 8'($urandom_range(0, 255));
                it.url_last  = 1'($urandom_range(0, 1));
                it.url_empty = 1'b1;
                send_item(it, 1'b0, none);
            end
            it.url_byte  = body[i];
            it.url_last  = (i == body.size() - 1);
            it.url_empty = 1'b0;
            send_item(it, 1'b0, none);
        end
    endtask

    // Result sink with random stall bursts
    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        res_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Check each accepted result against the oldest pending verdict
    always @(posedge i_clk) begin
        aksm_pkg::t_result due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, matches %b hits %b", $time,
                         res_if.url_matches, res_if.keyword_hits);
                mismatches++;
            end else begin
                due = verdict_q.pop_front();
                if (res_if.url_matches !== due.url_matches) begin
                    $display("%0t: url_matches expected %b actual %b", $time,
                             due.url_matches, res_if.url_matches);
                    mismatches++;
                end
                if (res_if.keyword_hits !== due.keyword_hits) begin
                    $display("%0t: keyword_hits expected %b actual %b", $time,
                             due.keyword_hits, res_if.keyword_hits);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        int          phase;
        int unsigned phase_end;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        url_if.valid     = 1'b0;
        url_if.url_byte  = '0;
        url_if.url_last  = 1'b0;
        url_if.url_empty = 1'b0;
        kw_count         = '0;
        kw_lens          = '0;
        foreach (kw_chars[k]) kw_chars[k] = '0;
        clear_url();

        // No keywords in use: everything matches
        known_row(8'hFF, 1'b1, 1'b1, 1'b1, 4'b0000);
        known_row(8'h00, 1'b1, 1'b0, 1'b1, 4'b0000);
        // Count above the limit clamps to four; writes past the map are dropped
        cfg_row(aksm_pkg::REG_KEYWORD_COUNT, 64'd7);
        cfg_row(CFG_IDX_SPARE_LO, '1);
        // Four empty keywords: hit an empty URL only
        known_row(8'h00, 1'b0, 1'b1, 1'b1, 4'b1111);
        known_row(8'hFF, 1'b1, 1'b0, 1'b0, 4'b0000);
        // "ab", eight 0xFF, eight 0xFF with length clamped from 15, "c"
        cfg_row(aksm_pkg::REG_KEYWORD_CHARS_0, {48'd0, CH_B, CH_A});
        cfg_row(aksm_pkg::REG_KEYWORD_CHARS_1, '1);
        cfg_row(aksm_pkg::REG_KEYWORD_CHARS_2, '1);
        cfg_row(aksm_pkg::REG_KEYWORD_CHARS_3, {56'd0, CH_C});
        cfg_row(aksm_pkg::REG_KEYWORD_LENGTHS, 64'h1F82);
        url_row(CH_A, 1'b0, 1'b0);
        url_row(CH_B, 1'b0, 1'b0);
        url_row(CH_C, 1'b0, 1'b0);
        for (int i = 0; i < KLEN; i++) url_row(8'hFF, (i == KLEN - 1), 1'b0);
        // Keyword split across two URLs must not hit
        url_row(CH_A, 1'b1, 1'b0);
        url_row(CH_B, 1'b1, 1'b0);
        // Empty URL in the middle of a URL drops the partial URL
        url_row(CH_A, 1'b0, 1'b0);
        known_row(8'h00, 1'b0, 1'b1, 1'b0, 4'b0000);
        url_row(CH_B, 1'b1, 1'b0);
        // One keyword in use
        cfg_row(aksm_pkg::REG_KEYWORD_COUNT, 64'd1);
        cfg_row(CFG_IDX_SPARE_HI, '0);
        url_row(CH_A, 1'b0, 1'b0);
        known_row(CH_B, 1'b1, 1'b0, 1'b1, 4'b0001);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // Random phases, each with its own keyword set
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            program_keywords(phase);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_end = items_sent + $urandom_range(60, 180);
            while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
                if (items_sent + CALM_ITEMS >= TOTAL_ITEMS) idle_on = 1'b0;
                send_url();
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

endmodule
